>>> rtl/lsef_pkg.sv
// Package for the earliest-free list scheduler.
// Holds the shared widths, register map, state encoding and result record.
// Depends on nothing; every other file of the block uses it but lsef_ram.
package lsef_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned PROC_W  = 3;
  localparam int unsigned CFG_W   = 4;

  // Default number of processor entries in the state memory
  localparam int unsigned MAX_PROCS_DEF = 8;

  // APB register map
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_PROCS_IN_USE = 2'd0;
  localparam logic [CFG_W-1:0]   PROCS_RESET       = 4'd2;

  // Scheduler sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } lsef_state_e;

  // One finished result, handed from the core to the output stage
  typedef struct packed {
    logic [PROC_W-1:0] assigned_processor;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] task_number;
    logic [TIME_W-1:0] makespan;
    logic              overflow;
  } lsef_res_t;

endpackage

>>> rtl/lsef_if.sv
// Channel interfaces of the earliest-free list scheduler.
// Task input channel and result output channel, valid/ready handshake.
// Depends on lsef_pkg for field widths.
interface lsef_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsef_pkg::DUR_W-1:0]   task_duration;

  modport source (output valid, output task_duration, input ready);
  modport sink   (input valid, input task_duration, output ready);
endinterface

interface lsef_out_if;
  logic                         valid;
  logic                         ready;
  logic [lsef_pkg::PROC_W-1:0]  assigned_processor;
  logic [lsef_pkg::TIME_W-1:0]  start_time;
  logic [lsef_pkg::TIME_W-1:0]  end_time;
  logic [lsef_pkg::TIME_W-1:0]  task_number;
  logic [lsef_pkg::TIME_W-1:0]  makespan;
  logic                         overflow;

  modport source (output valid, output assigned_processor, output start_time,
                  output end_time, output task_number, output makespan,
                  output overflow, input ready);
  modport sink   (input valid, input assigned_processor, input start_time,
                  input end_time, input task_number, input makespan,
                  input overflow, output ready);
endinterface

>>> rtl/lsef_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the per-processor finish time and tie stamp store.
// No dependencies.
module lsef_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lsef_cfg.sv
// APB configuration register of the earliest-free list scheduler.
// Holds processors_in_use; depends on lsef_pkg for the register map.
module lsef_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsef_pkg::PADDR_W-1:0] paddr,
  input  logic [lsef_pkg::PDATA_W-1:0] pwdata,
  output logic [lsef_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output logic [lsef_pkg::CFG_W-1:0]   procs_o
);

  logic [lsef_pkg::CFG_W-1:0] procs_q;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == lsef_pkg::ADDR_PROCS_IN_USE);

  // Capture the register on the access phase of a write transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      procs_q <= lsef_pkg::PROCS_RESET;
    end else if (wr_en) begin
      procs_q <= pwdata[lsef_pkg::CFG_W-1:0];
    end
  end

  // Read back; unmapped addresses return zero
  always_comb begin
    prdata = '0;
    if (paddr == lsef_pkg::ADDR_PROCS_IN_USE) begin
      prdata = lsef_pkg::PDATA_W'(procs_q);
    end
  end

  assign procs_o = procs_q;

endmodule

>>> rtl/lsef_core.sv
// Scheduling core: scans the processor store, picks the earliest-free
// processor, and writes back its new finish time and tie stamp.
// Depends on lsef_pkg and lsef_ram.
module lsef_core #(
  parameter int unsigned MAX_PROCS = lsef_pkg::MAX_PROCS_DEF,
  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lsef_pkg::CFG_W-1:0]  procs_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lsef_pkg::DUR_W-1:0]  task_duration_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output lsef_pkg::lsef_res_t         res_o
);

  localparam int unsigned TW = lsef_pkg::TIME_W;

  lsef_pkg::lsef_state_e state_q, state_d;

  logic [IdxW-1:0]               rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]               last_q, last_d;
  logic [lsef_pkg::DUR_W-1:0]    dur_q, dur_d;
  logic [MAX_PROCS-1:0]          written_q;
  logic [TW-1:0]                 next_stamp_q, tasks_q, largest_q;
  logic                          ovf_q;

  // Compare stage, registered behind the memory read
  logic                          cmp_v_q;
  logic [IdxW-1:0]               cmp_idx_q;
  logic                          cmp_written_q;
  logic [IdxW-1:0]               best_idx_q;
  logic [TW-1:0]                 best_f_q, best_age_q;

  // Memory port signals
  logic                          ram_re, ram_we;
  logic [2*TW-1:0]               ram_rdata, ram_wdata;

  logic [TW-1:0]                 cur_f, cur_s, cur_age;
  logic                          take;
  logic [TW:0]                   sum;
  logic [TW-1:0]                 end_t;
  logic                          sat;
  logic                          commit;

  lsef_ram #(
    .Width (2 * TW),
    .Depth (MAX_PROCS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (best_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as their reset value
  always_comb begin
    if (cmp_written_q) begin
      cur_f = ram_rdata[2*TW-1:TW];
      cur_s = ram_rdata[TW-1:0];
    end else begin
      cur_f = '0;
      cur_s = TW'(cmp_idx_q);
    end
    cur_age = next_stamp_q - cur_s;
    take    = (cmp_idx_q == '0) || (cur_f < best_f_q) ||
              ((cur_f == best_f_q) && (cur_age > best_age_q));
  end

  // End time with saturation
  always_comb begin
    sum   = {1'b0, best_f_q} + (TW + 1)'(dur_q);
    sat   = sum[TW];
    end_t = sat ? {TW{1'b1}} : sum[TW-1:0];
  end

  assign commit    = (state_q == lsef_pkg::ST_UPDATE) && res_ready_i;
  assign ram_wdata = {end_t, next_stamp_q};
  assign ram_we    = commit;
  assign ram_re    = (state_q == lsef_pkg::ST_SCAN);

  // Sequencer: next state and control outputs
  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    last_d      = last_q;
    dur_d       = dur_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      lsef_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dur_d    = task_duration_i;
          rd_idx_d = '0;
          if (procs_i == '0) begin
            last_d = '0;
          end else if (32'(procs_i) > 32'(MAX_PROCS)) begin
            last_d = IdxW'(MAX_PROCS - 1);
          end else begin
            last_d = IdxW'(procs_i - 1'b1);
          end
          state_d = lsef_pkg::ST_SCAN;
        end
      end
      lsef_pkg::ST_SCAN: begin
        if (rd_idx_q == last_q) begin
          state_d = lsef_pkg::ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      lsef_pkg::ST_DRAIN: begin
        state_d = lsef_pkg::ST_UPDATE;
      end
      lsef_pkg::ST_UPDATE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = lsef_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsef_pkg::ST_IDLE;
      end
    endcase
  end

  // Result record for the output stage
  always_comb begin
    res_o.assigned_processor = lsef_pkg::PROC_W'(best_idx_q);
    res_o.start_time         = best_f_q;
    res_o.end_time           = end_t;
    res_o.task_number        = tasks_q;
    res_o.makespan           = (end_t > largest_q) ? end_t : largest_q;
    res_o.overflow           = ovf_q | sat;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lsef_pkg::ST_IDLE;
      rd_idx_q     <= '0;
      last_q       <= '0;
      cmp_v_q      <= 1'b0;
      written_q    <= '0;
      next_stamp_q <= TW'(MAX_PROCS);
      tasks_q      <= '0;
      largest_q    <= '0;
      ovf_q        <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      last_q   <= last_d;
      cmp_v_q  <= ram_re;
      if (commit) begin
        written_q[best_idx_q] <= 1'b1;
        next_stamp_q          <= next_stamp_q + 1'b1;
        tasks_q               <= tasks_q + 1'b1;
        largest_q             <= res_o.makespan;
        ovf_q                 <= res_o.overflow;
      end
    end
  end

  // Payload: task duration, compare pipeline and running best
  always_ff @(posedge clk_i) begin
    dur_q         <= dur_d;
    cmp_idx_q     <= rd_idx_q;
    cmp_written_q <= written_q[rd_idx_q];
    if (cmp_v_q && take) begin
      best_idx_q <= cmp_idx_q;
      best_f_q   <= cur_f;
      best_age_q <= cur_age;
    end
  end

endmodule

>>> rtl/list_scheduler_earliest_free.sv
// Earliest-free list scheduler: top level with APB register and output stage.
// Sequence: accept the task, scan the processor store, drain, then update and hand off the result.
// A new task is taken only once the previous result has been handed to the output stage;
//   the single read port of the processor store is scanned one entry per cycle.
// Reset: asynchronous active low; finish times read as zero, stamps as their index,
//   processors_in_use returns to 2. No clearing pass is needed.
module list_scheduler_earliest_free #(
  parameter int unsigned MAX_PROCS = lsef_pkg::MAX_PROCS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsef_pkg::PADDR_W-1:0] paddr,
  input  logic [lsef_pkg::PDATA_W-1:0] pwdata,
  output logic [lsef_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  lsef_in_if.sink                      in_i,
  lsef_out_if.source                   out_o
);

  logic [lsef_pkg::CFG_W-1:0] procs;
  logic                       res_valid, res_ready;
  lsef_pkg::lsef_res_t        res, out_q;
  logic                       out_v_q;

  lsef_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .procs_o (procs)
  );

  lsef_core #(
    .MAX_PROCS (MAX_PROCS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .procs_i         (procs),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .task_duration_i (in_i.task_duration),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // Output register: free when empty or drained this cycle
  assign res_ready = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid              = out_v_q;
  assign out_o.assigned_processor = out_q.assigned_processor;
  assign out_o.start_time         = out_q.start_time;
  assign out_o.end_time           = out_q.end_time;
  assign out_o.task_number        = out_q.task_number;
  assign out_o.makespan           = out_q.makespan;
  assign out_o.overflow           = out_q.overflow;

endmodule

>>> rtl/lsef_chk.sv
// Port-level checker for the earliest-free list scheduler, bound to the top.
// Depends on lsef_pkg for field widths.
module lsef_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lsef_pkg::TIME_W-1:0]  start_time,
  input logic [lsef_pkg::TIME_W-1:0]  end_time,
  input logic [lsef_pkg::TIME_W-1:0]  task_number,
  input logic [lsef_pkg::TIME_W-1:0]  makespan,
  input logic                         overflow
);

  logic                        out_acc;
  logic                        seen_q;
  logic [lsef_pkg::TIME_W-1:0] last_num_q;
  logic                        last_ovf_q;

  assign out_acc = out_valid && out_ready;

  // Track the previous result transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_num_q <= '0;
      last_ovf_q <= 1'b0;
    end else if (out_acc) begin
      seen_q     <= 1'b1;
      last_num_q <= task_number;
      last_ovf_q <= overflow;
    end
  end

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // End never precedes start, makespan covers end
  a_time_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (end_time >= start_time) && (makespan >= end_time))
    else $error("result times out of order");

  // Task numbers advance by one per result transaction
  a_task_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> task_number == last_num_q + 1'b1)
    else $error("task number skipped or repeated");

  // Overflow stays set once reported
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_ovf_q |-> overflow)
    else $error("overflow flag cleared");

endmodule

bind list_scheduler_earliest_free lsef_chk u_lsef_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .start_time  (out_o.start_time),
  .end_time    (out_o.end_time),
  .task_number (out_o.task_number),
  .makespan    (out_o.makespan),
  .overflow    (out_o.overflow)
);

>>> tb/lsef_sched_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the earliest-free list scheduler: snoops APB writes and both channels,
// predicts every result from its own processor table and compares field by field.
// Depends on lsef_pkg and on the channel interfaces of lsef_if.sv.
module lsef_sched_checker
  import lsef_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  lsef_in_if                 in_i,
  lsef_out_if                out_i,
  output int unsigned        err_count_o,
  output int unsigned        results_seen_o,
  output int unsigned        pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow copy of the scheduler state
  logic [TIME_W-1:0] finish_time [MAX_PROCS];
  logic [TIME_W-1:0] tie_stamp   [MAX_PROCS];
  logic [TIME_W-1:0] stamp_next;
  logic [TIME_W-1:0] tasks_placed;
  logic [TIME_W-1:0] makespan_so_far;
  logic              saturated;
  logic [CFG_W-1:0]  procs_cfg;

  lsef_res_t   expected_results [$];
  int unsigned errors;
  int unsigned seen_cnt;

  // Place one task on the earliest-free processor and return the result it produces
  function automatic lsef_res_t place_task(input logic [DUR_W-1:0] dur);
    int unsigned       active;
    int unsigned       pick;
    logic [TIME_W-1:0] pick_age;
    logic [TIME_W-1:0] age;
    logic [TIME_W:0]   sum;
    lsef_res_t         res;
    active = procs_cfg;
    if (active == 0) active = 1;
    if (active > MAX_PROCS) active = MAX_PROCS;
    pick = 0;
    pick_age = stamp_next - tie_stamp[0];
    // Lowest finish time wins; on a tie the processor that got there first
    for (int unsigned i = 1; i < active; i++) begin
      age = stamp_next - tie_stamp[i];
      if (finish_time[i] < finish_time[pick] ||
          (finish_time[i] == finish_time[pick] && age > pick_age)) begin
        pick = i;
        pick_age = age;
      end
    end
    res.assigned_processor = pick[PROC_W-1:0];
    res.start_time = finish_time[pick];
    sum = {1'b0, finish_time[pick]} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
    // Clamp at the top of the time range and latch the overflow
    if (sum[TIME_W]) begin
      res.end_time = '1;
      saturated = 1'b1;
    end else begin
      res.end_time = sum[TIME_W-1:0];
    end
    finish_time[pick] = res.end_time;
    tie_stamp[pick] = stamp_next;
    stamp_next = stamp_next + 1;
    if (res.end_time > makespan_so_far) makespan_so_far = res.end_time;
    res.task_number = tasks_placed;
    res.makespan = makespan_so_far;
    res.overflow = saturated;
    tasks_placed = tasks_placed + 1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lsef_res_t want;
    lsef_res_t got;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAX_PROCS; i++) begin
        finish_time[i] = '0;
        tie_stamp[i] = TIME_W'(i);
      end
      stamp_next = TIME_W'(MAX_PROCS);
      tasks_placed = '0;
      makespan_so_far = '0;
      saturated = 1'b0;
      procs_cfg = PROCS_RESET;
      expected_results.delete();
      errors = 0;
      seen_cnt = 0;
      err_count_o <= 0;
      results_seen_o <= 0;
      pending_o <= 0;
    end else begin
      // Track register writes; other addresses are ignored
      if (psel && penable && pwrite && pready && paddr == ADDR_PROCS_IN_USE) begin
        procs_cfg = pwdata[CFG_W-1:0];
      end
      if (in_i.valid && in_i.ready) begin
        expected_results.push_back(place_task(in_i.task_duration));
      end
      // Compare each result transaction with the oldest prediction
      if (out_i.valid && out_i.ready) begin
        got.assigned_processor = out_i.assigned_processor;
        got.start_time = out_i.start_time;
        got.end_time = out_i.end_time;
        got.task_number = out_i.task_number;
        got.makespan = out_i.makespan;
        got.overflow = out_i.overflow;
        seen_cnt++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: unexpected result: proc %0d start %0d end %0d task %0d mk %0d ovf %0b",
                     $time, got.assigned_processor, got.start_time, got.end_time,
                     got.task_number, got.makespan, got.overflow);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.assigned_processor !== want.assigned_processor ||
              got.start_time !== want.start_time || got.end_time !== want.end_time ||
              got.task_number !== want.task_number || got.makespan !== want.makespan ||
              got.overflow !== want.overflow) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: task %0d mismatch", $time, want.task_number);
              $display("  expected proc %0d start %0d end %0d task %0d mk %0d ovf %0b",
                       want.assigned_processor, want.start_time, want.end_time,
                       want.task_number, want.makespan, want.overflow);
              $display("  actual   proc %0d start %0d end %0d task %0d mk %0d ovf %0b",
                       got.assigned_processor, got.start_time, got.end_time,
                       got.task_number, got.makespan, got.overflow);
            end
          end
        end
      end
      err_count_o <= errors;
      results_seen_o <= seen_cnt;
      pending_o <= expected_results.size();
    end
  end

endmodule

>>> tb/list_scheduler_earliest_free_tb.sv
`timescale 1ns / 1ps
// Top of the earliest-free list scheduler testbench: clock, reset, APB writes,
// task stimulus and result back-pressure, plus the final verdict.
// Depends on lsef_pkg, lsef_if.sv, the scheduler RTL and lsef_sched_checker.
module list_scheduler_earliest_free_tb;
  import lsef_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 2'd3;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_TASKS     = 40;
  localparam int unsigned DRAIN_CYCLES   = 30;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_TASKS    = 100;
  localparam int unsigned BULK_TASKS     = 50;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lsef_in_if  in_ch ();
  lsef_out_if out_ch ();

  int unsigned err_count;
  int unsigned results_seen;
  int unsigned pending;
  int unsigned tasks_sent;
  bit          hold_req;
  bit          bulk_mode;

  list_scheduler_earliest_free u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  lsef_sched_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_i           (in_ch),
    .out_i          (out_ch),
    .err_count_o    (err_count),
    .results_seen_o (results_seen),
    .pending_o      (pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Guard against a hung run
  initial begin
    #5_000_000;
    $display("list_scheduler_earliest_free regression: fail");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 40);
  endfunction

  // Mix of zero, maximum, small (many ties) and full-range durations
  function automatic logic [DUR_W-1:0] pick_duration();
    unique case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2, 3, 4: begin
        return DUR_W'($urandom_range(1, 16));
      end
      default: begin
        return DUR_W'($urandom);
      end
    endcase
  endfunction

  // Two-phase APB write; random upper data bits around the register field
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    logic [PDATA_W-1:0] data;
    data = $urandom;
    data[CFG_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one task and hold it until the transaction completes
  task automatic send_task(input logic [DUR_W-1:0] dur, input bit no_gap);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.task_duration <= dur;
    do @(posedge clk_i); while (!in_ch.ready);
    tasks_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every task has come back
  task automatic wait_all_done();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_seen != tasks_sent);
  endtask

  // Result side: random stalls, one long hold-off on request, none in bulk mode
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (bulk_mode || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  // Task side and configuration
  initial begin
    logic [CFG_W-1:0] corner_procs [4];
    logic [CFG_W-1:0] procs;
    corner_procs = '{4'd1, 4'd8, 4'd0, 4'd15};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.task_duration = '0;
    tasks_sent = 0;
    hold_req = 1'b0;
    bulk_mode = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting of two processors: ties at zero, then field extremes
    send_task('0, 1'b0);
    send_task('0, 1'b0);
    send_task('0, 1'b0);
    send_task('1, 1'b0);
    send_task(16'h0001, 1'b0);
    send_task(16'hAAAA, 1'b0);
    send_task(16'h5555, 1'b0);

    // All eight processors; old stamps decide the ties
    wait_all_done();
    apb_write(ADDR_PROCS_IN_USE, 4'd8);
    send_task('0, 1'b0);
    send_task('0, 1'b0);
    send_task('0, 1'b0);
    send_task('0, 1'b0);
    send_task('1, 1'b0);
    send_task(16'h0001, 1'b0);
    send_task(16'h8000, 1'b0);
    send_task('0, 1'b0);

    // Zero processors acts as one
    wait_all_done();
    apb_write(ADDR_PROCS_IN_USE, 4'd0);
    send_task(16'h1234, 1'b0);
    send_task('0, 1'b0);

    // Above the processor count acts as all of them
    wait_all_done();
    apb_write(ADDR_PROCS_IN_USE, 4'd15);
    send_task('1, 1'b0);
    send_task(16'h0007, 1'b0);
    send_task(16'h0007, 1'b0);

    // Write to an unmapped address leaves the setting alone
    wait_all_done();
    apb_write(ADDR_UNMAPPED, 4'd1);
    send_task(16'h0003, 1'b0);

    // Random phases, corner settings first
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      wait_all_done();
      procs = (p < 4) ? corner_procs[p] : CFG_W'($urandom_range(0, 15));
      apb_write(ADDR_PROCS_IN_USE, procs);
      if (p == 2) hold_req = 1'b1;
      for (int unsigned k = 0; k < PHASE_TASKS; k++) begin
        // Let the result side drain completely once mid-phase
        if (p == 5 && k == PHASE_TASKS / 2) wait_all_done();
        send_task(pick_duration(), 1'b0);
      end
      if (p == 2) begin
        for (int unsigned k = 0; k < HOLD_TASKS; k++) send_task(pick_duration(), 1'b1);
      end
    end

    // Load a single processor with maximum durations, back to back
    wait_all_done();
    apb_write(ADDR_PROCS_IN_USE, 4'd1);
    bulk_mode = 1'b1;
    repeat (BULK_TASKS) send_task('1, 1'b1);
    bulk_mode = 1'b0;

    // Loaded processor beside lighter ones, then alone again
    wait_all_done();
    apb_write(ADDR_PROCS_IN_USE, 4'd3);
    repeat (30) send_task(pick_duration(), 1'b0);
    wait_all_done();
    apb_write(ADDR_PROCS_IN_USE, 4'd1);
    send_task('0, 1'b0);
    send_task('1, 1'b0);
    send_task(16'h0005, 1'b0);

    // Drain and decide
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("list_scheduler_earliest_free regression: pass");
    end else begin
      $display("list_scheduler_earliest_free regression: fail");
    end
    $finish;
  end

endmodule
